FILE: sv/mcf_pkg.sv
package mcf_pkg;

  localparam int COEF_W = 21;
  localparam int CTF_W  = 31;
  localparam int ROW_W  = 63;
  localparam int OUT_W  = 48;

  localparam logic [1:0] REG_ROW_0 = 2'd0;
  localparam logic [1:0] REG_ROW_1 = 2'd1;
  localparam logic [1:0] REG_ROW_2 = 2'd2;

  // index pairs (0,0) (1,1) (2,2) (0,1) (0,2) (1,2)
  localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [CTF_W-1:0]  ctf_t;

  typedef struct packed {
    logic signed [31:0] charge;
    logic signed [31:0] dipole_x;
    logic signed [31:0] dipole_y;
    logic signed [31:0] dipole_z;
    logic signed [31:0] quad_xx;
    logic signed [31:0] quad_yy;
    logic signed [31:0] quad_zz;
    logic signed [31:0] quad_xy_doubled;
    logic signed [31:0] quad_xz_doubled;
    logic signed [31:0] quad_yz_doubled;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] frac_charge;
    logic signed [OUT_W-1:0] frac_dipole_1;
    logic signed [OUT_W-1:0] frac_dipole_2;
    logic signed [OUT_W-1:0] frac_dipole_3;
    logic signed [OUT_W-1:0] frac_quad_11;
    logic signed [OUT_W-1:0] frac_quad_22;
    logic signed [OUT_W-1:0] frac_quad_33;
    logic signed [OUT_W-1:0] frac_quad_12;
    logic signed [OUT_W-1:0] frac_quad_13;
    logic signed [OUT_W-1:0] frac_quad_23;
  } out_item_t;

endpackage

FILE: sv/multipole_cart_to_frac.sv
// Channel | Direction | Handshake                         | Payload
// input   | in        | start, busy (accept: start & !busy)| in_item (in_item_t)
// result  | out       | out_valid strobe, one cycle       | out_item (out_item_t)
// config  | in/out    | psel, penable, pwrite, pready=1   | paddr, pwdata, prdata (64b)
//
// One item per cycle while busy is low; each accepted item is strobed on out_* from the last stage.
// Four register stages: input, multiply, sum, round/saturate.
// busy is high after reset and after each register write, while the
// two-stage quadrupole matrix builder settles; otherwise it stays low.
// Reset is synchronous; it clears the row registers and valid bits and loads the settle counter.
// The receiver cannot stall; results are never held.
module multipole_cart_to_frac
  import mcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int DP_W = COEF_W + 32;
  localparam int QP_W = CTF_W + 32;
  localparam int DS_W = DP_W + 2;
  localparam int QS_W = QP_W + 3;
  localparam logic [1:0] SETTLE = 2'd2;

  logic [ROW_W-1:0] row_r [3];
  logic [1:0]       hold_r;
  logic             cfg_wr;
  logic             accept;
  coef_t            a [3][3];
  ctf_t             ctf [6][6];

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign busy   = (hold_r != 2'd0);
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
      hold_r   <= SETTLE;
    end else begin
      if (cfg_wr) begin
        hold_r <= SETTLE;
        unique case (paddr[4:3])
          REG_ROW_0: row_r[0] <= pwdata[ROW_W-1:0];
          REG_ROW_1: row_r[1] <= pwdata[ROW_W-1:0];
          REG_ROW_2: row_r[2] <= pwdata[ROW_W-1:0];
          default: ;
        endcase
      end else if (busy) begin
        hold_r <= hold_r - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_ROW_0: prdata = {1'b0, row_r[0]};
      REG_ROW_1: prdata = {1'b0, row_r[1]};
      REG_ROW_2: prdata = {1'b0, row_r[2]};
      default:   prdata = '0;
    endcase
  end

  for (genvar r = 0; r < 3; r++) begin : g_ar
    for (genvar c = 0; c < 3; c++) begin : g_ac
      assign a[r][c] = row_r[r][COEF_W*c +: COEF_W];
    end
  end

  mcf_ctf u_ctf (
    .clk   (clk),
    .a_i   (a),
    .ctf_o (ctf)
  );

  // stage 1: input register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic signed [31:0] xd [3];
  logic signed [31:0] xq [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign xd[0] = s1_item_r.dipole_x;
  assign xd[1] = s1_item_r.dipole_y;
  assign xd[2] = s1_item_r.dipole_z;
  assign xq[0] = s1_item_r.quad_xx;
  assign xq[1] = s1_item_r.quad_yy;
  assign xq[2] = s1_item_r.quad_zz;
  assign xq[3] = s1_item_r.quad_xy_doubled;
  assign xq[4] = s1_item_r.quad_xz_doubled;
  assign xq[5] = s1_item_r.quad_yz_doubled;

  // stage 2: products
  logic                   s2_valid_r;
  logic signed [31:0]     s2_charge_r;
  logic signed [DP_W-1:0] dprod_r [3][3];
  logic signed [QP_W-1:0] qprod_r [6][6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_charge_r <= s1_item_r.charge;
  end

  for (genvar r = 0; r < 3; r++) begin : g_dr
    for (genvar c = 0; c < 3; c++) begin : g_dc
      logic signed [DP_W-1:0] p;
      assign p = a[r][c] * xd[r];
      always_ff @(posedge clk) begin
        dprod_r[r][c] <= p;
      end
    end
  end

  for (genvar r = 0; r < 6; r++) begin : g_qr
    for (genvar c = 0; c < 6; c++) begin : g_qc
      logic signed [QP_W-1:0] p;
      assign p = ctf[r][c] * xq[r];
      always_ff @(posedge clk) begin
        qprod_r[r][c] <= p;
      end
    end
  end

  // stage 3: sums
  logic                   s3_valid_r;
  logic signed [31:0]     s3_charge_r;
  logic signed [DS_W-1:0] dsum_r [3];
  logic signed [QS_W-1:0] qsum_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_charge_r <= s2_charge_r;
  end

  for (genvar c = 0; c < 3; c++) begin : g_ds
    always_ff @(posedge clk) begin
      dsum_r[c] <= DS_W'(dprod_r[0][c]) + DS_W'(dprod_r[1][c]) + DS_W'(dprod_r[2][c]);
    end
  end

  for (genvar c = 0; c < 6; c++) begin : g_qs
    always_ff @(posedge clk) begin
      qsum_r[c] <= QS_W'(qprod_r[0][c]) + QS_W'(qprod_r[1][c]) + QS_W'(qprod_r[2][c])
                 + QS_W'(qprod_r[3][c]) + QS_W'(qprod_r[4][c]) + QS_W'(qprod_r[5][c]);
    end
  end

  // stage 4: round half up, saturate the quadrupole results
  logic signed [OUT_W-1:0] dres [3];
  logic signed [OUT_W-1:0] qres [6];
  out_item_t               out_item_r;
  logic                    out_valid_r;

  for (genvar c = 0; c < 3; c++) begin : g_dround
    logic signed [DS_W-1:0] t;
    logic signed [DS_W-13:0] rnd;
    assign t    = dsum_r[c] + DS_W'(2048);
    assign rnd  = t[DS_W-1:12];
    assign dres[c] = OUT_W'(rnd);
  end

  for (genvar c = 0; c < 6; c++) begin : g_qround
    logic signed [QS_W-1:0]  t;
    logic signed [QS_W-13:0] rnd;
    logic                    ovf;
    assign t   = qsum_r[c] + QS_W'(2048);
    assign rnd = t[QS_W-1:12];
    assign ovf = (rnd[QS_W-13:OUT_W-1] != {(QS_W-12-OUT_W+1){rnd[QS_W-13]}});
    always_comb begin
      priority if (ovf && rnd[QS_W-13]) begin
        qres[c] = {1'b1, {(OUT_W-1){1'b0}}};
      end else if (ovf) begin
        qres[c] = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        qres[c] = rnd[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
    out_item_r.frac_charge   <= OUT_W'(s3_charge_r);
    out_item_r.frac_dipole_1 <= dres[0];
    out_item_r.frac_dipole_2 <= dres[1];
    out_item_r.frac_dipole_3 <= dres[2];
    out_item_r.frac_quad_11  <= qres[0];
    out_item_r.frac_quad_22  <= qres[1];
    out_item_r.frac_quad_33  <= qres[2];
    out_item_r.frac_quad_12  <= qres[3];
    out_item_r.frac_quad_13  <= qres[4];
    out_item_r.frac_quad_23  <= qres[5];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without an item accepted four cycles earlier");

  a_charge_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.frac_charge == OUT_W'($past(in_item.charge, 4)))
    else $error("charge not passed through");

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("item could be accepted while matrix settles");

  a_busy_only_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !cfg_wr |=> !busy)
    else $error("busy raised without a register write");

endmodule

FILE: sv/mcf_ctf.sv
module mcf_ctf
  import mcf_pkg::*;
(
  input  logic  clk,
  input  coef_t a_i   [3][3],
  output ctf_t  ctf_o [6][6]
);

  // row r = input pair (i,j), column c = output pair (k,m)
  for (genvar r = 0; r < 6; r++) begin : g_row
    for (genvar c = 0; c < 6; c++) begin : g_col
      localparam int I = PAIR_A[r];
      localparam int J = PAIR_B[r];
      localparam int K = PAIR_A[c];
      localparam int M = PAIR_B[c];

      logic signed [2*COEF_W-1:0] p0_r;
      logic signed [2*COEF_W-1:0] p1_r;
      logic signed [2*COEF_W:0]   sum;

      if (c < 3) begin : g_diag
        always_ff @(posedge clk) begin
          p0_r <= a_i[I][K] * a_i[J][K];
          p1_r <= '0;
        end
      end else begin : g_cross
        always_ff @(posedge clk) begin
          p0_r <= a_i[I][K] * a_i[J][M];
          p1_r <= a_i[J][K] * a_i[I][M];
        end
      end

      assign sum = (2*COEF_W+1)'(p0_r) + (2*COEF_W+1)'(p1_r) + (2*COEF_W+1)'(2048);

      always_ff @(posedge clk) begin
        ctf_o[r][c] <= sum[2*COEF_W:12];
      end
    end
  end

endmodule

FILE: verif/multipole_cart_to_frac_tb.sv
module multipole_cart_to_frac_tb
  import mcf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FIELDS = 10;
  localparam int NUM_ROWS   = 3;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 300;
  localparam int SETTLE     = 6;

  class frac_scoreboard;
    logic [ROW_W-1:0] row [NUM_ROWS];
    out_item_t        frac_q [$];
    int unsigned      errors;

    function new();
      foreach (row[i]) row[i] = '0;
      errors = 0;
    endfunction

    function void load_row(int idx, logic [63:0] value);
      if (idx < NUM_ROWS) row[idx] = value[ROW_W-1:0];
    endfunction

    function longint rnd12(longint v);
      return (v + 64'sd2048) >>> 12;
    endfunction

    function logic [OUT_W-1:0] sat48(longint v);
      if (v > 64'sd140737488355327) v = 64'sd140737488355327;
      if (v < -64'sd140737488355328) v = -64'sd140737488355328;
      return v[OUT_W-1:0];
    endfunction

    function out_item_t transform(in_item_t it);
      longint             a [3][3];
      longint             ctf [6][6];
      longint             x [NUM_FIELDS];
      longint             e;
      longint             acc;
      logic signed [COEF_W-1:0] fld;
      logic [NUM_FIELDS*OUT_W-1:0] flat;
      int i, j, k, m;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          fld = row[r][COEF_W*c +: COEF_W];
          a[r][c] = fld;
        end
      end
      x[0] = it.charge;
      x[1] = it.dipole_x;
      x[2] = it.dipole_y;
      x[3] = it.dipole_z;
      x[4] = it.quad_xx;
      x[5] = it.quad_yy;
      x[6] = it.quad_zz;
      x[7] = it.quad_xy_doubled;
      x[8] = it.quad_xz_doubled;
      x[9] = it.quad_yz_doubled;
      // row = input pair, column = output pair
      for (int c = 0; c < 6; c++) begin
        k = PAIR_A[c];
        m = PAIR_B[c];
        for (int r = 0; r < 6; r++) begin
          i = PAIR_A[r];
          j = PAIR_B[r];
          if (c < 3) begin
            e = a[i][k] * a[j][k];
          end else begin
            e = a[i][k] * a[j][m] + a[j][k] * a[i][m];
          end
          ctf[r][c] = rnd12(e);
        end
      end
      flat[NUM_FIELDS*OUT_W-1 -: OUT_W] = x[0][OUT_W-1:0];
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int r = 0; r < 3; r++) acc += a[r][c] * x[1+r];
        flat[NUM_FIELDS*OUT_W-1-OUT_W*(1+c) -: OUT_W] = sat48(rnd12(acc));
      end
      for (int c = 0; c < 6; c++) begin
        acc = 0;
        for (int r = 0; r < 6; r++) acc += ctf[r][c] * x[4+r];
        flat[NUM_FIELDS*OUT_W-1-OUT_W*(4+c) -: OUT_W] = sat48(rnd12(acc));
      end
      return out_item_t'(flat);
    endfunction

    function void note_input(in_item_t it);
      frac_q.push_back(transform(it));
    endfunction

    function string field_label(int f);
      case (f)
        0: return "frac_charge";
        1: return "frac_dipole_1";
        2: return "frac_dipole_2";
        3: return "frac_dipole_3";
        4: return "frac_quad_11";
        5: return "frac_quad_22";
        6: return "frac_quad_33";
        7: return "frac_quad_12";
        8: return "frac_quad_13";
        default: return "frac_quad_23";
      endcase
    endfunction

    function void check_result(out_item_t got);
      logic [NUM_FIELDS*OUT_W-1:0] wf;
      logic [NUM_FIELDS*OUT_W-1:0] gf;
      if (frac_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $realtime, got);
        errors++;
        return;
      end
      wf = frac_q.pop_front();
      gf = got;
      for (int f = 0; f < NUM_FIELDS; f++) begin
        if (gf[NUM_FIELDS*OUT_W-1-OUT_W*f -: OUT_W] !== wf[NUM_FIELDS*OUT_W-1-OUT_W*f -: OUT_W])
        begin
          $display("%0t: %s expected %h actual %h", $realtime, field_label(f),
                   wf[NUM_FIELDS*OUT_W-1-OUT_W*f -: OUT_W],
                   gf[NUM_FIELDS*OUT_W-1-OUT_W*f -: OUT_W]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return frac_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  frac_scoreboard sb = new();

  multipole_cart_to_frac u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  function logic [31:0] rand_word();
    logic [31:0] v;
    int unsigned pick;
    v    = $urandom;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v = {{11{v[20]}}, v[20:0]};
    end else if (pick >= 85) begin
      case ($urandom_range(4))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h0000_0000;
        3: v = 32'hFFFF_FFFF;
        default: v = 32'h0000_0800;
      endcase
    end
    return v;
  endfunction

  function in_item_t rand_item();
    logic [NUM_FIELDS*32-1:0] flat;
    for (int f = 0; f < NUM_FIELDS; f++) flat[32*f +: 32] = rand_word();
    return in_item_t'(flat);
  endfunction

  function in_item_t fill_item(logic [31:0] v, bit alt);
    logic [NUM_FIELDS*32-1:0] flat;
    for (int f = 0; f < NUM_FIELDS; f++) flat[32*f +: 32] = (alt && f[0]) ? ~v : v;
    return in_item_t'(flat);
  endfunction

  function logic [COEF_W-1:0] rand_coef();
    logic [COEF_W-1:0] v;
    int unsigned pick;
    v    = COEF_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      v = {{7{v[13]}}, v[13:0]};
    end else if (pick >= 85) begin
      case ($urandom_range(4))
        0: v = 21'h10_0000;
        1: v = 21'h0F_FFFF;
        2: v = 21'h00_0000;
        3: v = 21'h1F_FFFF;
        default: v = 21'h00_1000;
      endcase
    end
    return v;
  endfunction

  function logic [63:0] rand_row();
    return {1'($urandom_range(1)), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_input(it);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= rand_item();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(8 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.load_row(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check(input int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(8 * idx);
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (prdata[ROW_W-1:0] !== sb.row[idx]) begin
      $display("%0t: row %0d readback expected %h actual %h", $realtime, idx,
               sb.row[idx], prdata[ROW_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_matrix(input logic [63:0] r0, input logic [63:0] r1,
                             input logic [63:0] r2);
    drain();
    cfg_write(0, r0);
    cfg_write(1, r1);
    cfg_write(2, r2);
    // out-of-range register, must not disturb the matrix
    cfg_write(NUM_ROWS, rand_row());
    for (int r = 0; r < NUM_ROWS; r++) cfg_read_check(r);
  endtask

  task automatic directed_items();
    send_item(fill_item(32'h0000_0000, 1'b0));
    send_item(fill_item(32'h7FFF_FFFF, 1'b0));
    send_item(fill_item(32'h8000_0000, 1'b0));
    send_item(fill_item(32'hFFFF_FFFF, 1'b0));
    send_item(fill_item(32'h5555_5555, 1'b1));
    send_item(fill_item(32'h7FFF_FFFF, 1'b1));
    send_item(fill_item(32'h0000_0800, 1'b0));
    send_item(fill_item(32'hFFFF_F800, 1'b0));
  endtask

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset matrix: only the charge survives
    for (int r = 0; r < NUM_ROWS; r++) cfg_read_check(r);
    send_item(fill_item(32'h8000_0000, 1'b1));
    send_item(fill_item(32'h7FFF_FFFF, 1'b0));

    // most negative entries in rows 1 and 2 and in row 0 column 0, top bit set
    load_matrix(64'hF000_0100_0010_0000 | 64'h8000_0000_0000_0000,
                {1'b1, {3{21'h10_0000}}}, {1'b1, {3{21'h10_0000}}});
    directed_items();
    load_matrix({1'b0, {3{21'h0F_FFFF}}}, {1'b0, {3{21'h0F_FFFF}}},
                {1'b0, {3{21'h0F_FFFF}}});
    directed_items();
    // one lsb per entry: rounding of half values
    load_matrix({1'b0, {3{21'h00_0001}}}, {1'b1, {3{21'h00_0001}}},
                {1'b0, {3{21'h00_0001}}});
    directed_items();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_matrix(rand_row(), rand_row(), rand_row());
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_item(rand_item());
        if (ph == 1 && n == PHASE_LEN / 2) drain();
        if (ph < PHASES - 1 && $urandom_range(3) == 0) idle_cycles($urandom_range(1, 6));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
